FILE: rtl/wms_pkg.sv
package wms_pkg;

  // Number of ring slots. The slot pointer wraps naturally and the average is
  // an arithmetic shift, so the window must be a power of two.
  localparam int WINDOW = 64;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int IDX_W  = SLOT_W + 1;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = VAL_W + SLOT_W;
  localparam int SLOT_INDEX_W = 6;

  localparam logic [1:0] OP_GAUGE   = 2'd0;
  localparam logic [1:0] OP_COUNTER = 2'd1;
  localparam logic [1:0] OP_REPEAT  = 2'd2;
  localparam logic [1:0] OP_REDUCE  = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef struct packed {
    logic idle;
    logic scan_start;
    logic scan_run;
    logic write_back;
    logic finish;
  } wms_cmd_t;

  typedef struct packed {
    logic accepted;
    logic accept_reduce;
    logic scan_done;
    logic out_free;
  } wms_status_t;

endpackage

FILE: rtl/wms_in_if.sv
interface wms_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic signed [31:0]       sample_value;

  modport source (output valid, output op, output sample_value, input ready);
  modport sink (input valid, input op, input sample_value, output ready);
endinterface

FILE: rtl/wms_out_if.sv
interface wms_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] recorded_value;
  logic signed [31:0] window_avg;
  logic signed [31:0] window_min;
  logic signed [31:0] window_max;
  logic [5:0]         slot_index;

  modport source (output valid, output recorded_value, output window_avg,
                  output window_min, output window_max, output slot_index,
                  input ready);
  modport sink (input valid, input recorded_value, input window_avg,
                input window_min, input window_max, input slot_index,
                output ready);
endinterface

FILE: rtl/wms_ctrl.sv
module wms_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  wms_pkg::wms_status_t status,
  output wms_pkg::wms_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (status.accepted) begin
          if (status.accept_reduce) begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        // Previous-slot data is ready; retire once the result register frees.
        if (status.out_free) begin
          cmd.write_back = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.scan_done && status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/wms_datapath.sv
module wms_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  wms_pkg::wms_cmd_t    cmd,
  output wms_pkg::wms_status_t status,
  wms_in_if.sink               sample,
  wms_out_if.source            result
);

  logic [1:0]                          op_q;
  logic signed [wms_pkg::VAL_W-1:0]    val_q;
  logic [wms_pkg::SLOT_W-1:0]          write_slot;
  logic [wms_pkg::SLOT_W-1:0]          slot_next;
  logic [wms_pkg::SLOT_W-1:0]          rd_addr;

  logic signed [wms_pkg::VAL_W-1:0]    gauge_mem [wms_pkg::WINDOW];
  logic signed [wms_pkg::VAL_W-1:0]    counter_mem [wms_pkg::WINDOW];
  logic [wms_pkg::WINDOW-1:0]          gvalid;
  logic [wms_pkg::WINDOW-1:0]          cvalid;
  logic signed [wms_pkg::VAL_W-1:0]    gauge_q;
  logic signed [wms_pkg::VAL_W-1:0]    counter_q;
  logic                                gvalid_q;
  logic                                cvalid_q;
  logic signed [wms_pkg::VAL_W-1:0]    prev_gauge;
  logic signed [wms_pkg::VAL_W-1:0]    prev_counter;

  logic signed [wms_pkg::VAL_W:0]      diff;
  logic signed [wms_pkg::VAL_W-1:0]    delta;
  logic signed [wms_pkg::VAL_W-1:0]    rec;
  logic                                c_we;
  logic signed [wms_pkg::VAL_W-1:0]    c_wdata;

  logic [wms_pkg::IDX_W-1:0]           scan_idx;
  logic                                scan_end;
  logic                                rd_live;
  logic signed [wms_pkg::SUM_W-1:0]    sum_acc;
  logic signed [wms_pkg::SUM_W-1:0]    sum_shift;
  logic signed [wms_pkg::VAL_W-1:0]    min_acc;
  logic signed [wms_pkg::VAL_W-1:0]    max_acc;

  logic                                out_valid;

  assign sample.ready = cmd.idle;
  assign status.accepted      = sample.valid && cmd.idle;
  assign status.accept_reduce = (sample.op == wms_pkg::OP_REDUCE);
  assign status.out_free      = !out_valid || result.ready;

  assign scan_end         = (scan_idx == wms_pkg::IDX_W'(wms_pkg::WINDOW));
  assign status.scan_done = scan_end && !rd_live;

  assign slot_next = write_slot + wms_pkg::SLOT_W'(1);
  assign rd_addr   = cmd.scan_run ? scan_idx[wms_pkg::SLOT_W-1:0] : write_slot;

  always_ff @(posedge clk) begin
    if (status.accepted) begin
      op_q  <= sample.op;
      val_q <= sample.sample_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
    end else if (cmd.write_back) begin
      write_slot <= slot_next;
    end
  end

  // Slot stores: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (cmd.write_back) begin
      gauge_mem[slot_next] <= rec;
    end
    gauge_q <= gauge_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      counter_mem[slot_next] <= c_wdata;
    end
    counter_q <= counter_mem[rd_addr];
  end

  // Per-slot valid bits stand in for clearing the stores at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      gvalid   <= '0;
      cvalid   <= '0;
      gvalid_q <= 1'b0;
      cvalid_q <= 1'b0;
    end else begin
      if (cmd.write_back) begin
        gvalid[slot_next] <= 1'b1;
      end
      if (c_we) begin
        cvalid[slot_next] <= 1'b1;
      end
      gvalid_q <= gvalid[rd_addr];
      cvalid_q <= cvalid[rd_addr];
    end
  end

  assign prev_gauge   = gvalid_q ? gauge_q : '0;
  assign prev_counter = cvalid_q ? counter_q : '0;

  // Counter delta, clamped at zero and saturated at the largest value.
  assign diff = {val_q[wms_pkg::VAL_W-1], val_q}
              - {prev_counter[wms_pkg::VAL_W-1], prev_counter};

  always_comb begin
    if (diff[wms_pkg::VAL_W]) begin
      delta = '0;
    end else if (diff[wms_pkg::VAL_W-1]) begin
      delta = wms_pkg::VAL_MAX;
    end else begin
      delta = diff[wms_pkg::VAL_W-1:0];
    end
  end

  always_comb begin
    case (op_q)
      wms_pkg::OP_GAUGE:   rec = val_q;
      wms_pkg::OP_COUNTER: rec = delta;
      wms_pkg::OP_REPEAT:  rec = prev_gauge;
      default:             rec = '0;
    endcase
  end

  always_comb begin
    c_we    = cmd.write_back && (op_q inside {wms_pkg::OP_COUNTER, wms_pkg::OP_REPEAT});
    c_wdata = (op_q == wms_pkg::OP_COUNTER) ? val_q : prev_counter;
  end

  // Window walk: one address issued per cycle, its data folded in during the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_live  <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_idx <= '0;
      rd_live  <= 1'b0;
    end else begin
      rd_live <= cmd.scan_run && !scan_end;
      if (cmd.scan_run && !scan_end) begin
        scan_idx <= scan_idx + wms_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      sum_acc <= '0;
      min_acc <= wms_pkg::VAL_MAX;
      max_acc <= '0;
    end else if (rd_live) begin
      sum_acc <= sum_acc + {{wms_pkg::SLOT_W{prev_gauge[wms_pkg::VAL_W-1]}}, prev_gauge};
      if (prev_gauge < min_acc) begin
        min_acc <= prev_gauge;
      end
      if (prev_gauge > max_acc) begin
        max_acc <= prev_gauge;
      end
    end
  end

  assign sum_shift = sum_acc >>> wms_pkg::SLOT_W;

  always_ff @(posedge clk) begin
    if (cmd.write_back) begin
      result.recorded_value <= rec;
      result.window_avg     <= '0;
      result.window_min     <= '0;
      result.window_max     <= '0;
      result.slot_index     <= wms_pkg::SLOT_INDEX_W'(slot_next);
    end else if (cmd.finish) begin
      result.recorded_value <= '0;
      result.window_avg     <= sum_shift[wms_pkg::VAL_W-1:0];
      result.window_min     <= min_acc;
      result.window_max     <= max_acc;
      result.slot_index     <= wms_pkg::SLOT_INDEX_W'(write_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write_back || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid = out_valid;

endmodule

FILE: rtl/windowed_metric_stats_top.sv
// Sliding-window statistics over a ring of WINDOW Q16.16 sample slots.
// The sample channel carries one operation per transfer: a gauge value, a
// counter running total, a repeat of the last slot, or a reduce request.
// The result channel returns exactly one transfer per operation, in order.
// A gauge, counter or repeat operation reads the previous slot from the
// slot stores at its transfer, has that data in the following cycle, and
// writes the new slot at the end of that cycle, or later if the result
// register is still full. Its result is registered at that write-back,
// and the block takes no new operation until then.
// A reduce walks all WINDOW slots through the gauge store read port, one
// slot per cycle, and presents average, minimum and maximum once the walk is
// done and the result register is free; this walk sets the rate for reduces.
// Reset clears the write slot and the per-slot valid bits, so every slot
// reads as zero afterwards; no clearing pass is needed.
// The result sits in an output register. While the receiver stalls, the
// block still takes the next operation and works on it; it holds that
// operation's write-back until the waiting result has been taken.
module windowed_metric_stats_top (
  input  logic       clk,
  input  logic       rst,
  wms_in_if.sink     sample,
  wms_out_if.source  result
);

  wms_pkg::wms_cmd_t    cmd;
  wms_pkg::wms_status_t status;

  // The sequencer decides when to take, retire and walk.
  wms_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // The datapath holds both slot stores, the write slot and the result register.
  wms_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .sample (sample),
    .result (result)
  );

  // After a transfer in, the block is busy in the cycle that follows.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("sample channel ready right after a transfer");

  // The result register is loaded only when it is empty or being emptied.
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.write_back || cmd.finish) |-> (!result.valid || result.ready))
    else $error("result register overwritten while still held");

  // A reduce starts a window walk and never writes a slot.
  a_reduce_walks: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready && sample.op == wms_pkg::OP_REDUCE)
      |=> (cmd.scan_run && !cmd.write_back))
    else $error("reduce did not start a window walk");

endmodule

FILE: dv/tb_windowed_metric_stats_top.sv
module tb_windowed_metric_stats_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wms_pkg::*;

  // Random items per flow-control phase. There are four phases, so the random
  // part comes to roughly 650 operations on top of the directed opening.
  localparam int RANDOM_PER_PHASE = 163;
  localparam int MAX_PRINTED_ERRORS = 100;

  // One operation as the sender presents it.
  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } metric_op_t;

  // One result as the block should return it.
  typedef struct packed {
    logic signed [31:0] recorded;
    logic signed [31:0] avg;
    logic signed [31:0] min_val;
    logic signed [31:0] max_val;
    logic [5:0]         slot;
  } stats_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Local copies of everything the testbench drives. Giving them initial
  // values means the block never sees an unknown input, even before reset.
  logic               in_valid = 1'b0;
  logic [1:0]         in_op    = OP_GAUGE;
  logic signed [31:0] in_value = '0;
  logic               out_ready = 1'b0;

  wms_in_if  sample_if ();
  wms_out_if result_if ();

  assign sample_if.valid        = in_valid;
  assign sample_if.op           = in_op;
  assign sample_if.sample_value = in_value;
  assign result_if.ready        = out_ready;

  windowed_metric_stats_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .result (result_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Operations waiting to be driven, and results waiting to be seen.
  metric_op_t    pending_ops_q[$];
  stats_result_t expected_stats_q[$];

  // Flow-control knobs, in percent. They only change between phases, when
  // the block is drained, so the clocked blocks can read them freely.
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  int error_count   = 0;
  int checked_count = 0;
  int op_count [4]  = '{default: 0};

  // Predictor state: a private copy of both slot stores and the write slot.
  logic signed [31:0] pred_gauge   [WINDOW];
  logic signed [31:0] pred_counter [WINDOW];
  int                 pred_slot;

  // Running total that the stimulus uses to build plausible counter runs.
  logic signed [31:0] counter_track = '0;

  initial begin
    for (int i = 0; i < WINDOW; i++) begin
      pred_gauge[i]   = '0;
      pred_counter[i] = '0;
    end
    pred_slot = 0;
  end

  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTED_ERRORS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic queue_op(input logic [1:0] op, input logic [31:0] value);
    pending_ops_q.push_back('{op: op, value: value});
  endtask

  // Mostly small Q16.16 values around zero, with a fair share of full-range
  // words and the extreme codes, so sums and comparisons get exercised at
  // both ends of the range.
  function automatic logic [31:0] rand_q16();
    case ($urandom_range(9))
      0, 1, 2: return $urandom();
      3: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      default: return $urandom_range(32'h0014_0000) - 32'h000A_0000;
    endcase
  endfunction

  // Works out the result of one accepted operation and updates the private
  // copy of the slot stores the same way the block should.
  function automatic stats_result_t predict_stats(input logic [1:0] op,
                                                  input logic signed [31:0] value);
    stats_result_t      r;
    logic signed [63:0] sum;
    logic signed [63:0] delta;
    logic signed [63:0] avg;
    logic signed [31:0] g;
    logic signed [31:0] rec;
    int                 prev;
    int                 slot;
    int                 i;
    r = '0;
    if (op == OP_REDUCE) begin
      // A reduce reads every slot and changes nothing. The minimum starts
      // from the first slot, the maximum from zero.
      sum = '0;
      slot = pred_slot;
      for (i = 0; i < WINDOW; i++) begin
        g = pred_gauge[(slot + i) % WINDOW];
        sum = sum + g;
        if (i == 0 || g < r.min_val) begin
          r.min_val = g;
        end
        if (g > r.max_val) begin
          r.max_val = g;
        end
      end
      // Floor division, so negative sums round toward minus infinity.
      if (sum >= 0) begin
        avg = sum / WINDOW;
      end else begin
        avg = -((-sum + WINDOW - 1) / WINDOW);
      end
      r.avg = avg[31:0];
    end else begin
      prev = pred_slot;
      slot = (pred_slot + 1) % WINDOW;
      if (op == OP_GAUGE) begin
        rec = value;
      end else if (op == OP_COUNTER) begin
        // Difference from the previous total, clamped at zero when the
        // counter goes backwards and saturated when it overflows 32 bits.
        delta = value;
        delta = delta - pred_counter[prev];
        if (delta < 0) begin
          delta = '0;
        end
        if (delta > VAL_MAX) begin
          delta = VAL_MAX;
        end
        pred_counter[slot] = value;
        rec = delta[31:0];
      end else begin
        pred_counter[slot] = pred_counter[prev];
        rec = pred_gauge[prev];
      end
      pred_gauge[slot] = rec;
      pred_slot = slot;
      r.recorded = rec;
    end
    r.slot = slot[5:0];
    return r;
  endfunction

  // Sender. An operation becomes a transfer at an edge where valid and ready
  // are both high; that is the moment its expected result is worked out.
  // The next operation, if one is pending, is then presented unless the idle roll says to wait.
  // Valid only drops when nothing is presented, so it is assigned once per
  // edge and never dips between back-to-back transfers.
  always @(posedge clk) begin : drive_samples
    metric_op_t next_op;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && sample_if.ready) begin
        expected_stats_q.push_back(predict_stats(in_op, in_value));
        op_count[in_op] += 1;
      end
      if (!in_valid || sample_if.ready) begin
        if (pending_ops_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_op = pending_ops_q.pop_front();
          in_valid <= 1'b1;
          in_op    <= next_op.op;
          in_value <= next_op.value;
        end else begin
          // Idle cycles carry junk payload so the block must honor valid.
          in_valid <= 1'b0;
          in_op    <= 2'($urandom());
          in_value <= $urandom();
        end
      end
    end
  end

  // Receiver. Every result transfer is matched against the oldest expected
  // result, field by field. Ready is re-rolled on every edge.
  always @(posedge clk) begin : check_results
    stats_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (result_if.valid && out_ready) begin
        if (expected_stats_q.size() == 0) begin
          report_error("result transfer with no operation outstanding");
        end else begin
          want = expected_stats_q.pop_front();
          if (result_if.recorded_value !== want.recorded) begin
            report_error($sformatf("result %0d recorded_value got %h expected %h",
                                   checked_count, result_if.recorded_value, want.recorded));
          end
          if (result_if.window_avg !== want.avg) begin
            report_error($sformatf("result %0d window_avg got %h expected %h",
                                   checked_count, result_if.window_avg, want.avg));
          end
          if (result_if.window_min !== want.min_val) begin
            report_error($sformatf("result %0d window_min got %h expected %h",
                                   checked_count, result_if.window_min, want.min_val));
          end
          if (result_if.window_max !== want.max_val) begin
            report_error($sformatf("result %0d window_max got %h expected %h",
                                   checked_count, result_if.window_max, want.max_val));
          end
          if (result_if.slot_index !== want.slot) begin
            report_error($sformatf("result %0d slot_index got %0d expected %0d",
                                   checked_count, result_if.slot_index, want.slot));
          end
          checked_count++;
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    int burst;
    int kind;
    int k;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // Queue changes happen on the falling edge, away from the clocked blocks.
    @(negedge clk);

    // Directed opening. The very first operation is a counter, whose
    // previous slot is slot 0 and still holds zero after reset.
    queue_op(OP_COUNTER, 32'h0005_0000);
    queue_op(OP_REDUCE,  32'hA5A5_A5A5);
    queue_op(OP_COUNTER, 32'h7FFF_FFFF);
    // Counter going backwards records zero.
    queue_op(OP_COUNTER, 32'h8000_0000);
    // From the most negative total to the most positive one: the delta does
    // not fit in 32 bits and must saturate.
    queue_op(OP_COUNTER, 32'h7FFF_FFFF);
    queue_op(OP_GAUGE,   32'h7FFF_FFFF);
    queue_op(OP_GAUGE,   32'h8000_0000);
    queue_op(OP_REPEAT,  32'hFFFF_FFFF);
    queue_op(OP_GAUGE,   32'h0000_0000);
    queue_op(OP_GAUGE,   32'hFFFF_FFFF);
    queue_op(OP_REDUCE,  32'h0000_0000);
    // A repeat copies the counter store too, so the next counter's delta is
    // taken against the copied total.
    queue_op(OP_COUNTER, 32'h0001_0000);
    queue_op(OP_REPEAT,  32'h5A5A_5A5A);
    queue_op(OP_COUNTER, 32'h0003_0000);
    queue_op(OP_COUNTER, 32'h0003_0000);
    queue_op(OP_GAUGE,   32'hFFFF_0000);
    queue_op(OP_GAUGE,   32'h8000_0000);
    queue_op(OP_REPEAT,  32'h0000_0000);
    // Reduce does not move the write slot, so two in a row must agree.
    queue_op(OP_REDUCE,  32'h7FFF_FFFF);
    queue_op(OP_REDUCE,  32'h8000_0000);
    queue_op(OP_GAUGE,   32'h0000_8000);

    for (phase = 0; phase < 4; phase++) begin
      // From the second phase on the block is drained here, so the knobs can change safely.
      case (phase)
        0: begin
          sender_idle_pct = 0;  receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 55; receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;  receiver_stall_pct = 55;
        end
        default: begin
          sender_idle_pct = 7;  receiver_stall_pct = 7;
        end
      endcase

      // Random part, built as bursts: runs of gauge samples, runs of counter
      // totals that mostly climb, short runs of repeats, and reduces that
      // look at whatever the ring holds by then.
      n = 0;
      while (n < RANDOM_PER_PHASE) begin
        kind = $urandom_range(9);
        if (kind <= 3) begin
          burst = $urandom_range(12, 1);
          for (k = 0; k < burst; k++) begin
            queue_op(OP_GAUGE, rand_q16());
          end
        end else if (kind <= 6) begin
          burst = $urandom_range(12, 1);
          for (k = 0; k < burst; k++) begin
            case ($urandom_range(19))
              0: counter_track = counter_track - $urandom_range(32'h0003_0000);
              1: counter_track = $urandom();
              2: counter_track = counter_track + 32'h7FF0_0000;
              default: counter_track = counter_track + $urandom_range(32'h0004_0000);
            endcase
            queue_op(OP_COUNTER, counter_track);
          end
        end else if (kind == 7) begin
          burst = $urandom_range(4, 1);
          for (k = 0; k < burst; k++) begin
            queue_op(OP_REPEAT, $urandom());
          end
        end else begin
          burst = $urandom_range(2, 1);
          for (k = 0; k < burst; k++) begin
            queue_op(OP_REDUCE, $urandom());
          end
        end
        n += burst;
      end

      // Wait until every queued operation is sent and every expected result has come home.
      while (pending_ops_q.size() != 0 || in_valid || expected_stats_q.size() != 0) begin
        @(negedge clk);
      end
    end

    // Give a stray extra result time to show up; a reduce walk is the
    // longest the block ever takes.
    repeat (WINDOW + 8) @(negedge clk);

    $display("Checked %0d results: %0d gauge, %0d counter, %0d repeat, %0d reduce.",
             checked_count, op_count[OP_GAUGE], op_count[OP_COUNTER],
             op_count[OP_REPEAT], op_count[OP_REDUCE]);
    $display("Flow control ran free, with sender gaps, receiver stalls, and both; %0d errors.",
             error_count);
    if (error_count == 0 && expected_stats_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // A correct run needs under a tenth of this, even if every item were
  // a reduce with the receiver stalling half the time.
  initial begin : watchdog
    #5ms;
    $display("Timeout with %0d results still expected.", expected_stats_q.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/wms_pkg.sv
rtl/wms_in_if.sv
rtl/wms_out_if.sv
rtl/wms_ctrl.sv
rtl/wms_datapath.sv
rtl/windowed_metric_stats_top.sv
dv/tb_windowed_metric_stats_top.sv
